>>> rtl/rapt_pkg.sv
package rapt_pkg;

  localparam int unsigned LEAVES  = 1024;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ADDR_W  = 11;   // node index, root at 1, leaves at LEAVES..2*LEAVES-1
  localparam int unsigned BOUND_W = 12;   // holds up to 2*LEAVES for the open right bound
  localparam int unsigned DATA_W  = 32;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_L,
    ST_WR_L,
    ST_ADD_R,
    ST_WR_R,
    ST_RD,
    ST_RD_LAST
  } rapt_state_t;

endpackage

>>> rtl/range_add_point_read_tree_core.sv
// Range add / point read over 1024 positions, kept as a bottom-up segment tree
// in one 2048-word RAM: an add marks the canonical nodes covering the range,
// a read sums the nodes on the leaf-to-root path. After reset the block zeroes
// the RAM with in_stall high. A read issues 11 RAM reads, one per tree level,
// and adds the last one in a finishing state. An add walks the tree level by
// level, doing a read-modify-write of each node it updates, and ends on a
// final bound check; a reversed range is accepted and dropped. Writes and
// reads go through the RAM's separate write and read ports. The result word
// is registered, so a new item is accepted while it waits on out_stall.
module range_add_point_read_tree_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [rapt_pkg::POS_W-1:0] in_range_start,
  input  logic [rapt_pkg::POS_W-1:0] in_range_end,
  input  logic signed [31:0] in_addend,
  input  logic [rapt_pkg::POS_W-1:0] in_read_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_read_value
);

  localparam int unsigned AW = rapt_pkg::ADDR_W;
  localparam int unsigned BW = rapt_pkg::BOUND_W;
  localparam int unsigned DW = rapt_pkg::DATA_W;

  rapt_pkg::rapt_state_t state_r, state_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [BW-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [DW-1:0] addend_r, addend_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic          acc_en_r, acc_en_nxt;
  logic [DW-1:0] out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic          in_acc;
  logic          out_free;
  logic [DW-1:0] final_sum;

  assign in_stall  = (state_r != rapt_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign final_sum = acc_r + ram_rdata;

  rapt_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rapt_pkg::ST_CLEAR: begin
        if (clr_r == AW'((1 << AW) - 1)) state_nxt = rapt_pkg::ST_IDLE;
      end
      rapt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_action == rapt_pkg::ACT_READ) state_nxt = rapt_pkg::ST_RD;
          else if (in_range_start <= in_range_end) state_nxt = rapt_pkg::ST_ADD_L;
        end
      end
      rapt_pkg::ST_ADD_L: begin
        if (l_r >= r_r) state_nxt = rapt_pkg::ST_IDLE;
        else if (l_r[0]) state_nxt = rapt_pkg::ST_WR_L;
        else state_nxt = rapt_pkg::ST_ADD_R;
      end
      rapt_pkg::ST_WR_L: state_nxt = rapt_pkg::ST_ADD_R;
      rapt_pkg::ST_ADD_R: begin
        if (r_r[0]) state_nxt = rapt_pkg::ST_WR_R;
        else state_nxt = rapt_pkg::ST_ADD_L;
      end
      rapt_pkg::ST_WR_R: state_nxt = rapt_pkg::ST_ADD_L;
      rapt_pkg::ST_RD: begin
        if (p_r == AW'(1)) state_nxt = rapt_pkg::ST_RD_LAST;
      end
      rapt_pkg::ST_RD_LAST: begin
        if (out_free) state_nxt = rapt_pkg::ST_IDLE;
      end
      default: state_nxt = rapt_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_nxt       = clr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    p_nxt         = p_r;
    addend_nxt    = addend_r;
    acc_nxt       = acc_r;
    acc_en_nxt    = acc_en_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = l_r[AW-1:0];
    ram_wdata     = ram_rdata + addend_r;
    ram_re        = 1'b0;
    ram_raddr     = l_r[AW-1:0];
    case (state_r)
      rapt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      rapt_pkg::ST_IDLE: begin
        if (in_acc) begin
          l_nxt      = BW'(in_range_start) + BW'(rapt_pkg::LEAVES);
          r_nxt      = BW'(in_range_end) + BW'(rapt_pkg::LEAVES) + BW'(1);
          addend_nxt = in_addend;
          p_nxt      = AW'(in_read_position) + AW'(rapt_pkg::LEAVES);
          acc_nxt    = '0;
          acc_en_nxt = 1'b0;
        end
      end
      rapt_pkg::ST_ADD_L: begin
        ram_re    = (l_r < r_r) && l_r[0];
        ram_raddr = l_r[AW-1:0];
      end
      rapt_pkg::ST_WR_L: begin
        ram_we    = 1'b1;
        ram_waddr = l_r[AW-1:0];
        l_nxt     = l_r + BW'(1);
      end
      rapt_pkg::ST_ADD_R: begin
        if (r_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(r_r - BW'(1));
          r_nxt     = r_r - BW'(1);
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      rapt_pkg::ST_WR_R: begin
        ram_we    = 1'b1;
        ram_waddr = r_r[AW-1:0];
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
      end
      rapt_pkg::ST_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = p_r;
        p_nxt      = p_r >> 1;
        acc_en_nxt = 1'b1;
        if (acc_en_r) acc_nxt = final_sum;
      end
      rapt_pkg::ST_RD_LAST: begin
        if (out_free) begin
          out_nxt       = final_sum;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rapt_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      acc_en_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      acc_en_r    <= acc_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    p_r      <= p_nxt;
    addend_r <= addend_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_r;

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rapt_pkg::ST_CLEAR |-> in_stall)
    else $error("input accepted during clearing pass");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rapt_pkg::ST_CLEAR && ram_we) |-> ram_wdata == '0)
    else $error("clearing pass wrote nonzero word");

  a_left_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rapt_pkg::ST_WR_L |-> l_r[0])
    else $error("left bound update on even node");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == rapt_pkg::ST_RD_LAST) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

>>> rtl/rapt_ram.sv
module rapt_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> tb/range_add_point_read_tree_checker.sv
module range_add_point_read_tree_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [9:0]         in_range_start,
  input  logic [9:0]         in_range_end,
  input  logic signed [31:0] in_addend,
  input  logic [9:0]         in_read_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_read_value,
  output int                 fail_count,
  output int                 pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  // a point's value is just the sum of adds covering it
  logic [31:0] point_value [rapt_pkg::LEAVES];
  logic [31:0] expected_reads [$];

  initial begin
    fail_count    = 0;
    pending_reads = 0;
    for (int i = 0; i < rapt_pkg::LEAVES; i++) point_value[i] = '0;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && in_valid && !in_stall) begin
      if (in_action == rapt_pkg::ACT_READ) begin
        expected_reads = {expected_reads, point_value[in_read_position]};
      end else if (in_range_start <= in_range_end) begin
        for (int i = in_range_start; i <= in_range_end; i++)
          point_value[i] = point_value[i] + in_addend;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_read_value);
        fail_count++;
      end else begin
        want = expected_reads.pop_front();
        if (want !== out_read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want, out_read_value);
          fail_count++;
        end
      end
    end
    pending_reads = expected_reads.size();
  end
endmodule

>>> tb/tb_range_add_point_read_tree_core.sv
module tb_range_add_point_read_tree_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n, in_valid, in_stall, in_action, out_valid, out_stall;
  logic [9:0] in_range_start, in_range_end, in_read_position;
  logic signed [31:0] in_addend, out_read_value;
  int fail_count, pending_reads;
  int cycle_count;
  bit quiet;

  range_add_point_read_tree_core dut (.*);
  range_add_point_read_tree_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1000000) begin
        $display("tb_range_add_point_read_tree_core failed");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_word(logic act, logic [9:0] s, logic [9:0] e, logic [31:0] v,
                           logic [9:0] p);
    in_valid <= 1; in_action <= act; in_range_start <= s; in_range_end <= e;
    in_addend <= v; in_read_position <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic random_word();
    logic [9:0] s, e;
    logic [31:0] v;
    s = 10'($urandom); e = 10'($urandom);
    case ($urandom_range(0, 5))
      0: e = s;
      1: e = 10'(s + $urandom_range(0, 15));
      2: begin s = 0; e = 1023; end
      default: ;
    endcase
    v = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 255) - 128;
    send_word(1'($urandom_range(0, 1)), s, e, v, 10'($urandom));
  endtask

  initial begin
    quiet = 0;
    rst_n = 0; in_valid = 0; in_action = rapt_pkg::ACT_ADD; in_range_start = 0;
    in_range_end = 0; in_addend = 0; in_read_position = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: extremes, single points, reversed range, reads at the ends
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 0);
    send_word(rapt_pkg::ACT_ADD, 0, 1023, 32'h7fffffff, 0);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 1023);
    send_word(rapt_pkg::ACT_ADD, 0, 1023, 32'h80000000, 0);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 0);
    send_word(rapt_pkg::ACT_ADD, 1023, 1023, 32'hffffffff, 0);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 1023);
    send_word(rapt_pkg::ACT_ADD, 0, 0, 5, 0);
    send_word(rapt_pkg::ACT_READ, 1023, 1023, 32'hffffffff, 0);
    send_word(rapt_pkg::ACT_ADD, 600, 100, 77, 0);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 300);
    send_word(rapt_pkg::ACT_ADD, 511, 512, 3, 1023);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 511);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 512);
    send_word(rapt_pkg::ACT_ADD, 1, 1022, 32'h55555555, 0);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 1);
    send_word(rapt_pkg::ACT_READ, 0, 0, 0, 1022);
    in_valid <= 0;
    while (pending_reads != 0) @(negedge clk);
    for (int i = 0; i < 1900; i++) begin
      if (i == 1700) quiet = 1;
      random_word();
    end
    in_valid <= 0;
    while (pending_reads != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_reads == 0)
      $display("tb_range_add_point_read_tree_core passed");
    else
      $display("tb_range_add_point_read_tree_core failed");
    $finish;
  end
endmodule
